>>> sv/csu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cardinality sketch update block.
// No dependencies; used by csu_ctrl, csu_dp and cardinality_sketch_update.

package csu_pkg;

    // Default sketch geometry
    localparam int INDEX_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 51;

    // Fixed field widths
    localparam int HASH_W  = 64;
    localparam int SUM_W   = 64;
    localparam int COUNT_W = 13;
    localparam int RANK_W  = 6;

    // Item function codes; the unused code behaves as a query
    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [HASH_W-1:0] hash;
    } t_in_item;

    typedef struct packed {
        logic [SUM_W-1:0]   harmonic_sum;
        logic [COUNT_W-1:0] zero_count;
        logic               raised;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RANK,
        ST_UPD,
        ST_RESP,
        ST_CLR
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // capture input beat, issue store read
        logic rank_en;    // register rank and both sum terms
        logic upd;        // apply max update and load result
        logic resp;       // load result from current totals
        logic clr_start;  // return totals to the empty sketch
        logic clr_wr;     // zero one store entry and step pointer
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;   // clear pointer on final entry
    } t_status;

endpackage

>>> sv/csu_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the sketch block: handshakes, item flow and clear walks.
// Depends on csu_pkg.

module csu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_func,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  csu_pkg::t_status   i_status,
    output csu_pkg::t_cmd      o_cmd
);

    csu_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_out_free;
    logic            w_load;

    // Result slot is free when empty or being taken this cycle
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load      = o_cmd.upd || o_cmd.resp;
    assign o_out_valid = r_out_valid;
    assign o_in_stall  = (r_state != csu_pkg::ST_IDLE);

    // State and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csu_pkg::ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            csu_pkg::ST_INIT: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = csu_pkg::ST_IDLE;
                end
            end
            csu_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    priority if (i_func == csu_pkg::FUNC_ADD) begin
                        n_state = csu_pkg::ST_RANK;
                    end else if (i_func == csu_pkg::FUNC_CLEAR) begin
                        o_cmd.clr_start = 1'b1;
                        n_state         = csu_pkg::ST_CLR;
                    end else begin
                        n_state = csu_pkg::ST_RESP;
                    end
                end
            end
            csu_pkg::ST_RANK: begin
                o_cmd.rank_en = 1'b1;
                n_state       = csu_pkg::ST_UPD;
            end
            csu_pkg::ST_UPD: begin
                if (w_out_free) begin
                    o_cmd.upd = 1'b1;
                    n_state   = csu_pkg::ST_IDLE;
                end
            end
            csu_pkg::ST_RESP: begin
                if (w_out_free) begin
                    o_cmd.resp = 1'b1;
                    n_state    = csu_pkg::ST_IDLE;
                end
            end
            csu_pkg::ST_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = csu_pkg::ST_RESP;
                end
            end
            default: begin
                n_state = csu_pkg::ST_INIT;
            end
        endcase
    end

    // Result valid: set on load, dropped once taken
    always_comb begin
        priority if (w_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

>>> sv/csu_dp.sv
`timescale 1ns / 1ps
// Datapath for the sketch block: rank store, rank and term logic, totals,
// clear pointer and result register. Depends on csu_pkg.

module csu_dp #(
    parameter int INDEX_BITS = csu_pkg::INDEX_BITS_DEF,
    parameter int FRAC_BITS  = csu_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  csu_pkg::t_in_item   i_in,
    input  csu_pkg::t_cmd       i_cmd,
    output csu_pkg::t_status    o_status,
    output csu_pkg::t_out_item  o_out
);

    localparam int DEPTH = 1 << INDEX_BITS;
    localparam logic [csu_pkg::SUM_W-1:0]   SUM_INIT =
        csu_pkg::SUM_W'(1) << (INDEX_BITS + FRAC_BITS);
    localparam logic [csu_pkg::COUNT_W-1:0] COUNT_INIT = csu_pkg::COUNT_W'(DEPTH);
    localparam logic [csu_pkg::RANK_W:0]    RANK_CAP   =
        (csu_pkg::RANK_W+1)'(csu_pkg::HASH_W + 1 - INDEX_BITS);

    // Rank: leading zeros of the remainder plus one, cap when all zero
    function automatic logic [csu_pkg::RANK_W-1:0] rank_of(
        input logic [csu_pkg::HASH_W-1:0] rem
    );
        logic [csu_pkg::RANK_W:0] r;
        r = RANK_CAP;
        for (int i = 0; i < csu_pkg::HASH_W; i++) begin
            if (rem[i]) begin
                r = (csu_pkg::RANK_W+1)'(csu_pkg::HASH_W - i);
            end
        end
        return r[csu_pkg::RANK_W-1:0];
    endfunction

    // Truncated fixed-point 2^-rank
    function automatic logic [csu_pkg::SUM_W-1:0] term_of(
        input logic [csu_pkg::RANK_W-1:0] rank
    );
        logic [csu_pkg::RANK_W-1:0] sh;
        sh = csu_pkg::RANK_W'(FRAC_BITS) - rank;
        if (rank > csu_pkg::RANK_W'(FRAC_BITS)) begin
            return '0;
        end
        return csu_pkg::SUM_W'(1) << sh;
    endfunction

    logic [csu_pkg::RANK_W-1:0]  r_mem [0:DEPTH-1];
    logic [csu_pkg::RANK_W-1:0]  r_rd_data;
    logic [csu_pkg::HASH_W-1:0]  r_hash;
    logic [csu_pkg::RANK_W-1:0]  r_rank;
    logic [csu_pkg::RANK_W-1:0]  r_old;
    logic [csu_pkg::SUM_W-1:0]   r_new_term;
    logic [csu_pkg::SUM_W-1:0]   r_old_term;
    logic [csu_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [csu_pkg::COUNT_W-1:0] r_count, n_count;
    logic [INDEX_BITS-1:0]       r_ptr;
    csu_pkg::t_out_item          r_out;
    logic                        w_raise;
    logic [INDEX_BITS-1:0]       w_idx;
    logic                        w_we;
    logic [INDEX_BITS-1:0]       w_waddr;
    logic [csu_pkg::RANK_W-1:0]  w_wdata;

    assign w_idx = r_hash[csu_pkg::HASH_W-1 -: INDEX_BITS];
    assign o_status.clr_last = (r_ptr == {INDEX_BITS{1'b1}});
    assign o_out = r_out;

    // Store write port: clear walk or raised entry
    assign w_raise = (r_rank > r_old);
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_idx;
        w_wdata = r_rank;
        priority if (i_cmd.clr_wr) begin
            w_we    = 1'b1;
            w_waddr = r_ptr;
            w_wdata = '0;
        end else if (i_cmd.upd && w_raise) begin
            w_we = 1'b1;
        end
    end

    // Rank store, registered read at accept
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.accept) begin
            r_rd_data <= r_mem[i_in.hash[csu_pkg::HASH_W-1 -: INDEX_BITS]];
        end
    end

    // Beat capture and rank/term stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_hash <= i_in.hash;
        end
        if (i_cmd.rank_en) begin
            r_rank     <= rank_of(r_hash << INDEX_BITS);
            r_old      <= r_rd_data;
            r_new_term <= term_of(rank_of(r_hash << INDEX_BITS));
            r_old_term <= term_of(r_rd_data);
        end
    end

    // Totals after a raised add
    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        if (w_raise) begin
            n_sum = r_sum - r_old_term + r_new_term;
            if (r_old == '0 && r_count != '0) begin
                n_count = r_count - csu_pkg::COUNT_W'(1);
            end
        end
    end

    // Running totals and clear pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= SUM_INIT;
            r_count <= COUNT_INIT;
            r_ptr   <= '0;
        end else begin
            if (i_cmd.clr_start) begin
                r_sum   <= SUM_INIT;
                r_count <= COUNT_INIT;
            end else if (i_cmd.upd) begin
                r_sum   <= n_sum;
                r_count <= n_count;
            end
            if (i_cmd.clr_wr) begin
                r_ptr <= r_ptr + INDEX_BITS'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_out.harmonic_sum <= n_sum;
            r_out.zero_count   <= n_count;
            r_out.raised       <= w_raise;
        end else if (i_cmd.resp) begin
            r_out.harmonic_sum <= r_sum;
            r_out.zero_count   <= r_count;
            r_out.raised       <= 1'b0;
        end
    end

endmodule

>>> sv/cardinality_sketch_update.sv
`timescale 1ns / 1ps
// Cardinality sketch update engine: 2^INDEX_BITS rank registers with a running
// harmonic sum and empty-register count. Depends on csu_pkg, csu_ctrl, csu_dp.
//
// Usage:
//   Input channel i_in (func, hash) with i_in_valid / o_in_stall. func add
//   folds the hash into the rank store, query reports the totals, clear
//   empties the sketch; the unused code acts as a query.
//   Output channel o_out (harmonic_sum, zero_count, raised) with o_out_valid /
//   i_out_stall; exactly one result beat per input beat, in order.
// Timing:
//   One item is in flight at a time. Add: store read, rank and term stage,
//   then the update that loads the result. Query: the result is loaded from
//   the current totals. Clear: totals reset at accept, then a one-entry-per-
//   cycle walk over the single store write port zeroes every entry. The next
//   beat is taken at the edge after the result is loaded, while that result
//   may still wait in the output register.
// Reset:
//   After i_rst_n releases the store is cleared by a walk over all 2^INDEX_BITS
//   entries with o_in_stall high; totals start at the empty-sketch values.
// Stall:
//   A result held by i_out_stall stays stable; a finished update waits in
//   its last stage until the output register frees.

module cardinality_sketch_update #(
    parameter int INDEX_BITS = csu_pkg::INDEX_BITS_DEF,
    parameter int FRAC_BITS  = csu_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  csu_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output csu_pkg::t_out_item  o_out
);

    csu_pkg::t_cmd    w_cmd;
    csu_pkg::t_status w_status;

    // Sequencer
    csu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_in.func),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Datapath
    csu_dp #(
        .INDEX_BITS (INDEX_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_out    (o_out)
    );

endmodule

>>> tb/cardinality_sketch_update_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for cardinality_sketch_update: add, query, clear and
// the spare code, checked beat by beat against a behavioural sketch model.
// Depends on csu_pkg and the cardinality_sketch_update RTL.

module cardinality_sketch_update_test;

    import csu_pkg::*;

    localparam int          IDX_W       = INDEX_BITS_DEF;
    localparam int          FRAC_W      = FRAC_BITS_DEF;
    localparam int          REM_W       = HASH_W - IDX_W;
    localparam int          REG_COUNT   = 1 << IDX_W;
    localparam int          RANK_CAP    = HASH_W + 1 - IDX_W;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam int          RANDOM_ITEMS = 600;
    localparam int          MAX_CLEARS   = 12;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_item   in_beat = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_beat;

    cardinality_sketch_update DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    // Behavioural copy of the sketch
    logic [RANK_W-1:0]  sketch_ranks [REG_COUNT];
    logic [SUM_W-1:0]   sketch_sum;
    int                 sketch_empty;

    t_in_item   pending_items [$];
    t_out_item  expected_results [$];
    int         mismatches = 0;

    // Sender burst and gap state, receiver stall pattern state
    int         burst_left = 0;
    int         gap_left = 0;
    int         stall_mode = 0;
    int         stall_phase_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [SUM_W-1:0] rank_term(int rank);
        if (rank > FRAC_W) return '0;
        return 64'd1 << (FRAC_W - rank);
    endfunction

    function automatic int hash_rank(logic [HASH_W-1:0] hash);
        logic [HASH_W-1:0] rem;
        int                rank;
        rem = hash << IDX_W;
        if (rem == '0) return RANK_CAP;
        rank = 1;
        while (!rem[HASH_W-1]) begin
            rem = rem << 1;
            rank++;
        end
        return rank;
    endfunction

    function automatic void empty_sketch();
        foreach (sketch_ranks[i]) sketch_ranks[i] = '0;
        sketch_sum   = 64'(REG_COUNT) << FRAC_W;
        sketch_empty = REG_COUNT;
    endfunction

    // Fold one accepted beat into the sketch and return the expected result
    function automatic t_out_item absorb_item(t_in_item item);
        t_out_item res;
        int        idx;
        int        rank;
        int        old;
        res = '0;
        if (item.func == FUNC_ADD) begin
            idx  = int'(item.hash >> REM_W);
            rank = hash_rank(item.hash);
            old  = int'(sketch_ranks[idx]);
            if (rank > old) begin
                sketch_sum = sketch_sum - rank_term(old) + rank_term(rank);
                if (old == 0 && sketch_empty > 0) sketch_empty--;
                sketch_ranks[idx] = RANK_W'(rank);
                res.raised = 1'b1;
            end
        end else if (item.func == FUNC_CLEAR) begin
            empty_sketch();
        end
        res.harmonic_sum = sketch_sum;
        res.zero_count   = COUNT_W'(sketch_empty);
        return res;
    endfunction

    // Hash for register idx whose remainder has lz leading zeros; lz = REM_W is all zero
    function automatic logic [HASH_W-1:0] build_hash(int idx, int lz);
        logic [HASH_W-1:0] rem;
        logic [HASH_W-1:0] lead;
        rem = '0;
        if (lz < REM_W) begin
            lead = 64'd1 << (REM_W - 1 - lz);
            rem  = lead | ({$urandom, $urandom} & (lead - 1));
        end
        return (64'(idx) << REM_W) | rem;
    endfunction

    task automatic queue_item(logic [1:0] func, logic [HASH_W-1:0] hash);
        t_in_item item;
        item.func = func;
        item.hash = hash;
        pending_items.push_back(item);
    endtask

    task automatic queue_add(int idx, int lz);
        queue_item(FUNC_ADD, build_hash(idx, lz));
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ns: MISMATCH %s got %0h expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Driver: bursts of beats with random gaps; the payload holds while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) expected_results.push_back(absorb_item(in_beat));
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_beat  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 20);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: own stall pattern, then compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (stall_phase_left == 0) begin
            stall_mode       = $urandom_range(0, 2);
            stall_phase_left = $urandom_range(20, 80);
        end else begin
            stall_phase_left--;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= $urandom_range(0, 1);
            default: out_stall <= ($urandom_range(0, 5) != 0);
        endcase

        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result beat, sum", out_beat.harmonic_sum, '0);
            end else begin
                t_out_item want;
                want = expected_results.pop_front();
                if (out_beat.harmonic_sum !== want.harmonic_sum)
                    report_mismatch("harmonic_sum", out_beat.harmonic_sum, want.harmonic_sum);
                if (out_beat.zero_count !== want.zero_count)
                    report_mismatch("zero_count", 64'(out_beat.zero_count), 64'(want.zero_count));
                if (out_beat.raised !== want.raised)
                    report_mismatch("raised", 64'(out_beat.raised), 64'(want.raised));
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int func_pick;
        int idx;
        int lz;
        int clears;
        clears = 0;
        empty_sketch();

        // Directed: field extremes, rank cap, zero-weight ranks, non-raising adds
        queue_item(FUNC_QUERY, {$urandom, $urandom});
        queue_item(FUNC_ADD, '1);
        queue_item(FUNC_ADD, '0);
        queue_add(1, REM_W - 1);
        queue_add(2, REM_W - 2);
        queue_add(2, REM_W - 2);
        queue_add(2, 3);
        queue_add(REG_COUNT - 1, 10);
        queue_item(FUNC_UNUSED, '1);
        queue_item(FUNC_QUERY, '0);
        queue_item(FUNC_CLEAR, '1);
        queue_item(FUNC_QUERY, '1);
        queue_add(0, 0);
        queue_add(0, REM_W);
        queue_add(0, REM_W - 1);
        queue_add(REG_COUNT - 1, FRAC_W);
        queue_item(FUNC_CLEAR, '0);
        queue_add(5, 0);
        clears = 2;

        // Random: mostly adds, hot registers for repeat hits, realistic rank spread
        repeat (RANDOM_ITEMS) begin
            func_pick = $urandom_range(0, 99);
            if (func_pick < 85) begin
                idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, REG_COUNT - 1);
                lz  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, REM_W)
                                                   : $urandom_range(0, 4);
                queue_add(idx, lz);
            end else if (func_pick < 93) begin
                queue_item(FUNC_QUERY, {$urandom, $urandom});
            end else if (func_pick < 97 || clears >= MAX_CLEARS) begin
                queue_item(FUNC_UNUSED, {$urandom, $urandom});
            end else begin
                queue_item(FUNC_CLEAR, {$urandom, $urandom});
                clears++;
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #(5_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
